### rtl/core/xdnt_pkg.sv
// Shared types and codes for the XOR-distance node table.
// No dependencies; imported by xdnt_cmp and xor_distance_node_table_top.
package xdnt_pkg;

  localparam int unsigned IdW = 160;

  typedef enum logic [2:0] {
    FUNC_ADD    = 3'd0,
    FUNC_REMOVE = 3'd1,
    FUNC_FIND   = 3'd2,
    FUNC_GET    = 3'd3,
    FUNC_SORT   = 3'd4,
    FUNC_CLEAR  = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_MISSING = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_GET_RD,
    ST_GET_DATA,
    ST_SKEY_RD,
    ST_SKEY_LD,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] id_hi;
    logic [63:0] id_mid;
    logic [31:0] id_lo;
    logic [5:0]  entry_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  hit_index;
    logic [63:0] out_id_hi;
    logic [63:0] out_id_mid;
    logic [31:0] out_id_lo;
    logic [6:0]  entry_count;
  } out_word_t;

  typedef struct packed {
    logic eq;       // entry equals key
    logic farther;  // entry is farther from target than key
  } cmp_res_t;

endpackage

### rtl/core/xdnt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module xdnt_ram #(
  parameter int unsigned WIDTH = 160,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/xdnt_cmp.sv
// Shared compare unit: equality with a key and XOR-distance ordering.
// Depends on xdnt_pkg.
module xdnt_cmp (
  input  logic [xdnt_pkg::IdW-1:0] entry_i,
  input  logic [xdnt_pkg::IdW-1:0] key_i,
  input  logic [xdnt_pkg::IdW-1:0] target_i,
  output xdnt_pkg::cmp_res_t       res_o
);
  import xdnt_pkg::*;

  logic [IdW-1:0] dist_entry;
  logic [IdW-1:0] dist_key;

  // byte-wise msb-first distance order is plain unsigned order of the word
  assign dist_entry    = entry_i ^ target_i;
  assign dist_key      = key_i ^ target_i;
  assign res_o.eq      = (entry_i == key_i);
  assign res_o.farther = (dist_entry > dist_key);

endmodule

### rtl/core/xor_distance_node_table_top.sv
// XOR-distance node table: one word at a time, not ready while busy.
// Add, clear and bad codes answer straight from idle; get reads one RAM word;
// find/remove scan the entries in order, and remove then shifts each later
// entry down by one; sort is insertion sort on the shared comparator.
// Throughput is set by the single RAM read port and the sequencer loop.
// Reset (async, active low) empties the table; stored IDs are not cleared.
module xor_distance_node_table_top #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  xdnt_pkg::in_word_t in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output xdnt_pkg::out_word_t out_word_o
);
  import xdnt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW = CW + 7;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [AW-1:0]   j_q, j_d;
  func_e           func_q, func_d;
  logic [5:0]      eidx_q, eidx_d;
  logic [IdW-1:0]  key_q, key_d;
  logic [IdW-1:0]  tgt_q, tgt_d;
  status_e         rstat_q, rstat_d;
  logic [5:0]      rhit_q, rhit_d;
  logic [IdW-1:0]  rid_q, rid_d;
  logic            out_valid_q, out_valid_d;
  out_word_t       out_q, out_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [IdW-1:0]  ram_wdata, ram_rdata;
  cmp_res_t        cmp;

  logic [XW-1:0]   cnt_x, idx_p1, idx_p2, i_p1, eidx_x;
  logic [IdW-1:0]  in_id;

  assign cnt_x  = XW'(count_q);
  assign idx_p1 = XW'(idx_q) + XW'(1);
  assign idx_p2 = XW'(idx_q) + XW'(2);
  assign i_p1   = idx_p1;
  assign eidx_x = XW'(eidx_q);
  assign in_id  = {in_word_i.id_hi, in_word_i.id_mid, in_word_i.id_lo};

  xdnt_ram #(
    .WIDTH(IdW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  xdnt_cmp u_cmp (
    .entry_i (ram_rdata),
    .key_i   (key_q),
    .target_i(tgt_q),
    .res_o   (cmp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    j_q     <= j_d;
    func_q  <= func_d;
    eidx_q  <= eidx_d;
    key_q   <= key_d;
    tgt_q   <= tgt_d;
    rstat_q <= rstat_d;
    rhit_q  <= rhit_d;
    rid_q   <= rid_d;
    out_q   <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    j_d         = j_q;
    func_d      = func_q;
    eidx_d      = eidx_q;
    key_d       = key_q;
    tgt_d       = tgt_q;
    rstat_d     = rstat_q;
    rhit_d      = rhit_q;
    rid_d       = rid_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = idx_q;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          func_d  = func_e'(in_word_i.func);
          eidx_d  = in_word_i.entry_index;
          key_d   = in_id;
          tgt_d   = in_id;
          rstat_d = STAT_OK;
          rhit_d  = '0;
          rid_d   = '0;
          idx_d   = '0;
          state_d = ST_RESP;
          case (func_e'(in_word_i.func))
            FUNC_ADD: begin
              if (cnt_x >= XW'(TABLE_DEPTH)) begin
                rstat_d = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(count_q);
                ram_wdata = in_id;
                count_d   = count_q + CW'(1);
              end
            end
            FUNC_REMOVE, FUNC_FIND: begin
              if (count_q == '0) begin
                rstat_d = STAT_MISSING;
              end else begin
                state_d = ST_SCAN_RD;
              end
            end
            FUNC_GET: begin
              if (XW'(in_word_i.entry_index) >= cnt_x) begin
                rstat_d = STAT_MISSING;
              end else begin
                state_d = ST_GET_RD;
              end
            end
            FUNC_SORT: begin
              if (cnt_x >= XW'(2)) begin
                idx_d   = AW'(1);
                state_d = ST_SKEY_RD;
              end
            end
            FUNC_CLEAR: count_d = '0;
            default:    rstat_d = STAT_MISSING;
          endcase
        end
      end

      ST_SCAN_RD: begin
        ram_raddr = idx_q;
        state_d   = ST_SCAN_CMP;
      end

      ST_SCAN_CMP: begin
        if (cmp.eq) begin
          if (func_q == FUNC_FIND) begin
            rhit_d  = 6'(idx_q);
            state_d = ST_RESP;
          end else if (idx_p1 < cnt_x) begin
            state_d = ST_SHIFT_RD;
          end else begin
            count_d = count_q - CW'(1);
            state_d = ST_RESP;
          end
        end else if (idx_p1 == cnt_x) begin
          rstat_d = STAT_MISSING;
          state_d = ST_RESP;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = ST_SCAN_RD;
        end
      end

      // move entry idx+1 down to idx
      ST_SHIFT_RD: begin
        ram_raddr = AW'(idx_p1);
        state_d   = ST_SHIFT_WR;
      end

      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        if (idx_p2 < cnt_x) begin
          idx_d   = idx_q + AW'(1);
          state_d = ST_SHIFT_RD;
        end else begin
          count_d = count_q - CW'(1);
          state_d = ST_RESP;
        end
      end

      ST_GET_RD: begin
        ram_raddr = AW'(eidx_x);
        state_d   = ST_GET_DATA;
      end

      ST_GET_DATA: begin
        rid_d   = ram_rdata;
        state_d = ST_RESP;
      end

      // insertion sort: idx is the outer position, j the hole
      ST_SKEY_RD: begin
        ram_raddr = idx_q;
        state_d   = ST_SKEY_LD;
      end

      ST_SKEY_LD: begin
        key_d   = ram_rdata;
        j_d     = idx_q;
        state_d = ST_SORT_RD;
      end

      ST_SORT_RD: begin
        ram_raddr = j_q - AW'(1);
        state_d   = ST_SORT_CMP;
      end

      ST_SORT_CMP: begin
        if (cmp.farther) begin
          ram_we    = 1'b1;
          ram_waddr = j_q;
          ram_wdata = ram_rdata;
          j_d       = j_q - AW'(1);
          state_d   = (j_q == AW'(1)) ? ST_SORT_PUT : ST_SORT_RD;
        end else begin
          state_d = ST_SORT_PUT;
        end
      end

      ST_SORT_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = key_q;
        if (i_p1 == cnt_x) begin
          state_d = ST_RESP;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = ST_SKEY_RD;
        end
      end

      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.status      = rstat_q;
          out_d.hit_index   = rhit_q;
          out_d.out_id_hi   = rid_q[159:96];
          out_d.out_id_mid  = rid_q[95:32];
          out_d.out_id_lo   = rid_q[31:0];
          out_d.entry_count = 7'(count_q);
          state_d           = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
